### sv/slts_pkg.sv
// shared types, constants and keyword lookup for the source lexer token scanner
`timescale 1ns / 1ps
`default_nettype none

package slts_pkg;

    localparam int KEPT_CHARS_DEF    = 12;
    localparam int POSITION_BITS_DEF = 16;

    localparam int CHAR_W     = 8;
    localparam int KIND_W     = 6;
    localparam int LEN_W      = 8;
    localparam int HEAD_BYTES = 8;
    localparam int HEAD_W     = HEAD_BYTES * CHAR_W;
    localparam int START_W    = 16;
    localparam int KW_MAX_LEN = 11;

    localparam logic [LEN_W-1:0] LEN_MAX = 8'd255;

    // token queue between scanner and output channel
    localparam int TQ_DEPTH = 4;
    localparam int TQ_PTR_W = 2;
    localparam int TQ_LVL_W = 3;

    typedef enum logic [7:0] {
        MODE_IDLE   = 8'b0000_0001,
        MODE_IDENT  = 8'b0000_0010,
        MODE_INT    = 8'b0000_0100,
        MODE_STRING = 8'b0000_1000,
        MODE_OP     = 8'b0001_0000,
        MODE_SLASH  = 8'b0010_0000,
        MODE_BLOCK  = 8'b0100_0000,
        MODE_LINE   = 8'b1000_0000
    } mode_t;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_IDENT       = 6'd0;
    localparam kind_t KIND_CLASS       = 6'd1;
    localparam kind_t KIND_EXTENDS     = 6'd2;
    localparam kind_t KIND_KW_INT      = 6'd3;
    localparam kind_t KIND_KW_STRING   = 6'd4;
    localparam kind_t KIND_BREAK       = 6'd5;
    localparam kind_t KIND_PRINT       = 6'd6;
    localparam kind_t KIND_READ        = 6'd7;
    localparam kind_t KIND_RETURN      = 6'd8;
    localparam kind_t KIND_SUPER       = 6'd9;
    localparam kind_t KIND_IF          = 6'd10;
    localparam kind_t KIND_ELSE        = 6'd11;
    localparam kind_t KIND_FOR         = 6'd12;
    localparam kind_t KIND_NEW         = 6'd13;
    localparam kind_t KIND_CONSTRUCTOR = 6'd14;
    localparam kind_t KIND_INT_LIT     = 6'd15;
    localparam kind_t KIND_STR_LIT     = 6'd16;
    localparam kind_t KIND_GE          = 6'd17;
    localparam kind_t KIND_LE          = 6'd18;
    localparam kind_t KIND_NE          = 6'd19;
    localparam kind_t KIND_EQ          = 6'd20;
    localparam kind_t KIND_ASSIGN      = 6'd21;
    localparam kind_t KIND_PLUS        = 6'd22;
    localparam kind_t KIND_MINUS       = 6'd23;
    localparam kind_t KIND_STAR        = 6'd24;
    localparam kind_t KIND_SLASH       = 6'd25;
    localparam kind_t KIND_PERCENT     = 6'd26;
    localparam kind_t KIND_LT          = 6'd27;
    localparam kind_t KIND_GT          = 6'd28;
    localparam kind_t KIND_NOT         = 6'd29;
    localparam kind_t KIND_LPAREN      = 6'd30;
    localparam kind_t KIND_RPAREN      = 6'd31;
    localparam kind_t KIND_LBRACKET    = 6'd32;
    localparam kind_t KIND_RBRACKET    = 6'd33;
    localparam kind_t KIND_LBRACE      = 6'd34;
    localparam kind_t KIND_RBRACE      = 6'd35;
    localparam kind_t KIND_COMMA       = 6'd36;
    localparam kind_t KIND_DOT         = 6'd37;
    localparam kind_t KIND_SEMI        = 6'd38;
    localparam kind_t KIND_INVALID     = 6'd39;

    localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CH_HT         = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL         = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BANG       = 8'h21;
    localparam logic [CHAR_W-1:0] CH_QUOTE      = 8'h22;
    localparam logic [CHAR_W-1:0] CH_PERCENT    = 8'h25;
    localparam logic [CHAR_W-1:0] CH_LPAREN     = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN     = 8'h29;
    localparam logic [CHAR_W-1:0] CH_STAR       = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS       = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_COMMA      = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT        = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SLASH      = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SEMI       = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LT         = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_EQ         = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_GT         = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LBRACKET   = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACKET   = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_LBRACE     = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE     = 8'h7D;

    typedef struct packed {
        kind_t               kind;
        logic [LEN_W-1:0]    length;
        logic [HEAD_W-1:0]   head;
        logic [START_W-1:0]  start;
        logic                last;
    } token_t;

    typedef struct packed {
        mode_t               mode_next;
        logic [CHAR_W-1:0]   held_next;
        logic                push;
        logic                restart;
        logic [1:0]          n;
        token_t              r0;
        token_t              r1;
    } scan_out_t;

    typedef struct packed {
        logic [TQ_LVL_W-1:0] level;
        logic                room2;
    } fifo_stat_t;

    // txt[0] is the first token character
    function automatic kind_t keyword_kind(
        input logic [KW_MAX_LEN-1:0][CHAR_W-1:0] txt,
        input logic [LEN_W-1:0]                  len
    );
        kind_t kind;
        kind = KIND_IDENT;
        if (len == 8'd5 && {txt[0], txt[1], txt[2], txt[3], txt[4]} == "class")
            kind = KIND_CLASS;
        else if (len == 8'd7 &&
                 {txt[0], txt[1], txt[2], txt[3], txt[4], txt[5], txt[6]} == "extends")
            kind = KIND_EXTENDS;
        else if (len == 8'd3 && {txt[0], txt[1], txt[2]} == "int")
            kind = KIND_KW_INT;
        else if (len == 8'd6 &&
                 {txt[0], txt[1], txt[2], txt[3], txt[4], txt[5]} == "string")
            kind = KIND_KW_STRING;
        else if (len == 8'd5 && {txt[0], txt[1], txt[2], txt[3], txt[4]} == "break")
            kind = KIND_BREAK;
        else if (len == 8'd5 && {txt[0], txt[1], txt[2], txt[3], txt[4]} == "print")
            kind = KIND_PRINT;
        else if (len == 8'd4 && {txt[0], txt[1], txt[2], txt[3]} == "read")
            kind = KIND_READ;
        else if (len == 8'd6 &&
                 {txt[0], txt[1], txt[2], txt[3], txt[4], txt[5]} == "return")
            kind = KIND_RETURN;
        else if (len == 8'd5 && {txt[0], txt[1], txt[2], txt[3], txt[4]} == "super")
            kind = KIND_SUPER;
        else if (len == 8'd2 && {txt[0], txt[1]} == "if")
            kind = KIND_IF;
        else if (len == 8'd4 && {txt[0], txt[1], txt[2], txt[3]} == "else")
            kind = KIND_ELSE;
        else if (len == 8'd3 && {txt[0], txt[1], txt[2]} == "for")
            kind = KIND_FOR;
        else if (len == 8'd3 && {txt[0], txt[1], txt[2]} == "new")
            kind = KIND_NEW;
        else if (len == 8'd11 &&
                 {txt[0], txt[1], txt[2], txt[3], txt[4], txt[5], txt[6], txt[7],
                  txt[8], txt[9], txt[10]} == "constructor")
            kind = KIND_CONSTRUCTOR;
        return kind;
    endfunction

endpackage

`default_nettype wire

### sv/slts_char_if.sv
// valid/ready channel carrying one source character
`timescale 1ns / 1ps
`default_nettype none

interface slts_char_if;
    logic                            valid;
    logic                            ready;
    logic [slts_pkg::CHAR_W-1:0]     char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

### sv/slts_token_if.sv
// valid/ready channel carrying one scanned token
`timescale 1ns / 1ps
`default_nettype none

interface slts_token_if;
    logic                            valid;
    logic                            ready;
    logic [slts_pkg::KIND_W-1:0]     token_kind;
    logic [slts_pkg::LEN_W-1:0]      token_length;
    logic [slts_pkg::HEAD_W-1:0]     token_text_head;
    logic [slts_pkg::START_W-1:0]    token_start;
    logic                            last_of_run;

    modport source (output valid, output token_kind, output token_length,
                    output token_text_head, output token_start, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input token_length,
                    input token_text_head, input token_start, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

### sv/slts_scan.sv
// next-state and token logic of the scanner for one character
`timescale 1ns / 1ps
`default_nettype none

module slts_scan (
    input  slts_pkg::mode_t                                           mode,
    input  logic [slts_pkg::CHAR_W-1:0]                               held,
    input  logic [slts_pkg::CHAR_W-1:0]                               c,
    input  logic [slts_pkg::LEN_W-1:0]                                count,
    input  logic [slts_pkg::KW_MAX_LEN-1:0][slts_pkg::CHAR_W-1:0]     txt,
    input  logic [slts_pkg::START_W-1:0]                              tok_start,
    input  logic [slts_pkg::START_W-1:0]                              cur_pos,
    output slts_pkg::scan_out_t                                       res
);

    logic                                              is_alpha;
    logic                                              is_digit;
    logic                                              is_space;
    slts_pkg::kind_t                                   single_kind;
    slts_pkg::mode_t                                   idle_mode;
    logic [slts_pkg::CHAR_W-1:0]                       idle_held;
    logic                                              idle_begin;
    logic                                              idle_emit;
    slts_pkg::mode_t                                   mode_n;
    logic [slts_pkg::CHAR_W-1:0]                       held_n;
    logic                                              push;
    logic                                              emit0;
    logic                                              emit0_pushed;
    slts_pkg::kind_t                                   kind0;
    logic                                              run_idle;
    logic                                              emit1;
    logic [slts_pkg::LEN_W-1:0]                        count_p;
    logic [slts_pkg::HEAD_BYTES-1:0][slts_pkg::CHAR_W-1:0] head_cur;
    logic [slts_pkg::HEAD_BYTES-1:0][slts_pkg::CHAR_W-1:0] head_pushed;
    slts_pkg::token_t                                  tok0;
    slts_pkg::token_t                                  tok_idle;

    always_comb
    begin
        is_alpha = c inside {[slts_pkg::CH_UPPER_A:slts_pkg::CH_UPPER_Z],
                             [slts_pkg::CH_LOWER_A:slts_pkg::CH_LOWER_Z]};
        is_digit = c inside {[slts_pkg::CH_DIGIT_0:slts_pkg::CH_DIGIT_9]};
        is_space = c inside {[slts_pkg::CH_HT:slts_pkg::CH_CR], slts_pkg::CH_SPACE};
    end

    // kind of a character that is a whole token by itself
    always_comb
    begin
        case (c)
            slts_pkg::CH_PLUS:     single_kind = slts_pkg::KIND_PLUS;
            slts_pkg::CH_MINUS:    single_kind = slts_pkg::KIND_MINUS;
            slts_pkg::CH_STAR:     single_kind = slts_pkg::KIND_STAR;
            slts_pkg::CH_PERCENT:  single_kind = slts_pkg::KIND_PERCENT;
            slts_pkg::CH_LPAREN:   single_kind = slts_pkg::KIND_LPAREN;
            slts_pkg::CH_RPAREN:   single_kind = slts_pkg::KIND_RPAREN;
            slts_pkg::CH_LBRACKET: single_kind = slts_pkg::KIND_LBRACKET;
            slts_pkg::CH_RBRACKET: single_kind = slts_pkg::KIND_RBRACKET;
            slts_pkg::CH_LBRACE:   single_kind = slts_pkg::KIND_LBRACE;
            slts_pkg::CH_RBRACE:   single_kind = slts_pkg::KIND_RBRACE;
            slts_pkg::CH_COMMA:    single_kind = slts_pkg::KIND_COMMA;
            slts_pkg::CH_DOT:      single_kind = slts_pkg::KIND_DOT;
            slts_pkg::CH_SEMI:     single_kind = slts_pkg::KIND_SEMI;
            default:               single_kind = slts_pkg::KIND_INVALID;
        endcase
    end

    // fresh scan of the character from the idle mode
    always_comb
    begin
        idle_mode  = slts_pkg::MODE_IDLE;
        idle_held  = slts_pkg::CH_NUL;
        idle_begin = 1'b1;
        idle_emit  = 1'b0;
        if (is_space)
        begin
            idle_begin = 1'b0;
        end
        else if (is_alpha || c == slts_pkg::CH_UNDERSCORE)
        begin
            idle_mode = slts_pkg::MODE_IDENT;
        end
        else if (is_digit)
        begin
            idle_mode = slts_pkg::MODE_INT;
        end
        else if (c == slts_pkg::CH_SLASH)
        begin
            idle_mode = slts_pkg::MODE_SLASH;
            idle_held = c;
        end
        else if (c inside {slts_pkg::CH_LT, slts_pkg::CH_GT, slts_pkg::CH_BANG,
                           slts_pkg::CH_EQ})
        begin
            idle_mode = slts_pkg::MODE_OP;
            idle_held = c;
        end
        else if (c == slts_pkg::CH_QUOTE)
        begin
            idle_mode = slts_pkg::MODE_STRING;
        end
        else
        begin
            idle_emit = 1'b1;
        end
    end

    always_comb
    begin
        mode_n       = mode;
        held_n       = held;
        push         = 1'b0;
        emit0        = 1'b0;
        emit0_pushed = 1'b0;
        kind0        = slts_pkg::KIND_IDENT;
        run_idle     = 1'b0;
        case (mode)
            slts_pkg::MODE_IDENT:
            begin
                if (is_alpha || is_digit || c == slts_pkg::CH_UNDERSCORE)
                begin
                    push = 1'b1;
                end
                else
                begin
                    emit0    = 1'b1;
                    kind0    = slts_pkg::keyword_kind(txt, count);
                    run_idle = 1'b1;
                end
            end
            slts_pkg::MODE_INT:
            begin
                if (is_digit)
                begin
                    push = 1'b1;
                end
                else
                begin
                    emit0    = 1'b1;
                    kind0    = slts_pkg::KIND_INT_LIT;
                    run_idle = 1'b1;
                end
            end
            slts_pkg::MODE_STRING:
            begin
                // line breaks inside a string are dropped
                if (c != slts_pkg::CH_NL)
                begin
                    push = 1'b1;
                    if (c == slts_pkg::CH_QUOTE)
                    begin
                        emit0        = 1'b1;
                        emit0_pushed = 1'b1;
                        kind0        = slts_pkg::KIND_STR_LIT;
                        mode_n       = slts_pkg::MODE_IDLE;
                    end
                end
            end
            slts_pkg::MODE_OP:
            begin
                if (c == slts_pkg::CH_EQ)
                begin
                    push         = 1'b1;
                    emit0        = 1'b1;
                    emit0_pushed = 1'b1;
                    mode_n       = slts_pkg::MODE_IDLE;
                    held_n       = slts_pkg::CH_NUL;
                    case (held)
                        slts_pkg::CH_GT:   kind0 = slts_pkg::KIND_GE;
                        slts_pkg::CH_LT:   kind0 = slts_pkg::KIND_LE;
                        slts_pkg::CH_BANG: kind0 = slts_pkg::KIND_NE;
                        default:           kind0 = slts_pkg::KIND_EQ;
                    endcase
                end
                else
                begin
                    emit0    = 1'b1;
                    run_idle = 1'b1;
                    case (held)
                        slts_pkg::CH_GT:   kind0 = slts_pkg::KIND_GT;
                        slts_pkg::CH_LT:   kind0 = slts_pkg::KIND_LT;
                        slts_pkg::CH_BANG: kind0 = slts_pkg::KIND_NOT;
                        default:           kind0 = slts_pkg::KIND_ASSIGN;
                    endcase
                end
            end
            slts_pkg::MODE_SLASH:
            begin
                if (c == slts_pkg::CH_SLASH)
                begin
                    mode_n = slts_pkg::MODE_LINE;
                    held_n = slts_pkg::CH_NUL;
                end
                else if (c == slts_pkg::CH_STAR)
                begin
                    mode_n = slts_pkg::MODE_BLOCK;
                    held_n = slts_pkg::CH_NUL;
                end
                else
                begin
                    emit0    = 1'b1;
                    kind0    = slts_pkg::KIND_SLASH;
                    run_idle = 1'b1;
                end
            end
            slts_pkg::MODE_BLOCK:
            begin
                if (held == slts_pkg::CH_STAR && c == slts_pkg::CH_SLASH)
                begin
                    mode_n = slts_pkg::MODE_IDLE;
                    held_n = slts_pkg::CH_NUL;
                end
                else
                begin
                    held_n = (c == slts_pkg::CH_STAR) ? slts_pkg::CH_STAR : slts_pkg::CH_NUL;
                end
            end
            slts_pkg::MODE_LINE:
            begin
                if (c == slts_pkg::CH_NL)
                begin
                    mode_n = slts_pkg::MODE_IDLE;
                end
            end
            default:
            begin
                run_idle = 1'b1;
            end
        endcase
        if (run_idle)
        begin
            mode_n = idle_mode;
            held_n = idle_held;
        end
    end

    // text head of the held token, before and after appending this character
    always_comb
    begin
        count_p = (count == slts_pkg::LEN_MAX) ? slts_pkg::LEN_MAX : count + 8'd1;
        for (int i = 0; i < slts_pkg::HEAD_BYTES; i++)
        begin
            head_cur[i]    = (8'(i) < count) ? txt[i] : slts_pkg::CH_NUL;
            head_pushed[i] = (8'(i) < count)  ? txt[i] :
                             (8'(i) == count) ? c : slts_pkg::CH_NUL;
        end
    end

    always_comb
    begin
        emit1 = run_idle && idle_emit;

        tok0.kind   = kind0;
        tok0.length = emit0_pushed ? count_p : count;
        tok0.head   = emit0_pushed ? head_pushed : head_cur;
        tok0.start  = tok_start;
        tok0.last   = !emit1;

        tok_idle.kind   = single_kind;
        tok_idle.length = 8'd1;
        tok_idle.head   = slts_pkg::HEAD_W'(c);
        tok_idle.start  = cur_pos;
        tok_idle.last   = 1'b1;

        res.mode_next = mode_n;
        res.held_next = held_n;
        res.push      = push;
        res.restart   = run_idle && idle_begin;
        res.n         = {1'b0, emit0} + {1'b0, emit1};
        res.r0        = emit0 ? tok0 : tok_idle;
        res.r1        = tok_idle;
    end

endmodule

`default_nettype wire

### sv/slts_tok_fifo.sv
// four-entry token queue taking up to two tokens per cycle
`timescale 1ns / 1ps
`default_nettype none

module slts_tok_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            push_n,
    input  slts_pkg::token_t      slot0,
    input  slts_pkg::token_t      slot1,
    slts_token_if.source          tok,
    output slts_pkg::fifo_stat_t  stat
);

    slts_pkg::token_t                    mem_reg [slts_pkg::TQ_DEPTH];
    logic [slts_pkg::TQ_PTR_W-1:0]       wr_ptr_reg;
    logic [slts_pkg::TQ_PTR_W-1:0]       rd_ptr_reg;
    logic [slts_pkg::TQ_LVL_W-1:0]       level_reg;
    logic                                pop;
    slts_pkg::token_t                    head;

    assign pop  = tok.valid && tok.ready;
    assign head = mem_reg[rd_ptr_reg];

    assign tok.valid           = level_reg != '0;
    assign tok.token_kind      = head.kind;
    assign tok.token_length    = head.length;
    assign tok.token_text_head = head.head;
    assign tok.token_start     = head.start;
    assign tok.last_of_run     = head.last;

    assign stat.level = level_reg;
    assign stat.room2 = level_reg <= slts_pkg::TQ_LVL_W'(slts_pkg::TQ_DEPTH - 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + slts_pkg::TQ_PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + slts_pkg::TQ_PTR_W'(pop);
            level_reg  <= level_reg + slts_pkg::TQ_LVL_W'(push_n)
                                    - slts_pkg::TQ_LVL_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= slot0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_reg + slts_pkg::TQ_PTR_W'(1)] <= slot1;
        end
    end

endmodule

`default_nettype wire

### sv/source_lexer_token_scanner_core.sv
// source lexer token scanner: characters in, tokens out
//
//  channel    dir  payload                                             transfer
//  char_in    in   char_code                                           valid & ready
//  token_out  out  token_kind, token_length, token_text_head,          valid & ready
//                  token_start, last_of_run
//
// one character is taken per cycle while char_in.ready is high; its tokens
// land in a four-entry queue the next cycle, one token leaves per cycle while
// token_out.ready is high, so a character that closes two tokens is absorbed by the queue.
// char_in.ready is high while the queue has room for two tokens.
// reset clears mode, held operator, token length and positions; text store is
// not reset. a pending token at the end of input stays held.
`timescale 1ns / 1ps
`default_nettype none

module source_lexer_token_scanner_core #(
    parameter int KEPT_CHARS    = slts_pkg::KEPT_CHARS_DEF,
    parameter int POSITION_BITS = slts_pkg::POSITION_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    slts_char_if.sink     char_in,
    slts_token_if.source  token_out
);

    localparam int IDX_W = $clog2(KEPT_CHARS);

    slts_pkg::mode_t                                           mode_reg;
    logic [slts_pkg::CHAR_W-1:0]                               held_reg;
    logic [slts_pkg::LEN_W-1:0]                                count_reg;
    logic [POSITION_BITS-1:0]                                  pos_reg;
    logic [POSITION_BITS-1:0]                                  start_reg;
    logic [slts_pkg::CHAR_W-1:0]                               store_reg [KEPT_CHARS];
    logic [slts_pkg::KW_MAX_LEN-1:0][slts_pkg::CHAR_W-1:0]     txt;
    logic                                                      accept;
    slts_pkg::scan_out_t                                       scan_res;
    slts_pkg::fifo_stat_t                                      fifo_stat;
    logic [1:0]                                                push_n;

    assign accept        = char_in.valid && char_in.ready;
    assign char_in.ready = fifo_stat.room2;
    assign push_n        = accept ? scan_res.n : 2'd0;

    always_comb
    begin
        for (int i = 0; i < slts_pkg::KW_MAX_LEN; i++)
        begin
            txt[i] = store_reg[i];
        end
    end

    slts_scan u_scan (
        .mode      (mode_reg),
        .held      (held_reg),
        .c         (char_in.char_code),
        .count     (count_reg),
        .txt       (txt),
        .tok_start (slts_pkg::START_W'(start_reg)),
        .cur_pos   (slts_pkg::START_W'(pos_reg)),
        .res       (scan_res)
    );

    slts_tok_fifo u_tok_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_n (push_n),
        .slot0  (scan_res.r0),
        .slot1  (scan_res.r1),
        .tok    (token_out),
        .stat   (fifo_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= slts_pkg::MODE_IDLE;
            held_reg  <= slts_pkg::CH_NUL;
            count_reg <= '0;
            pos_reg   <= '0;
            start_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= scan_res.mode_next;
            held_reg <= scan_res.held_next;
            pos_reg  <= pos_reg + POSITION_BITS'(1);
            if (scan_res.restart)
            begin
                count_reg <= 8'd1;
                start_reg <= pos_reg;
            end
            else if (scan_res.push && count_reg != slts_pkg::LEN_MAX)
            begin
                count_reg <= count_reg + 8'd1;
            end
        end
    end

    // only the first KEPT_CHARS characters of a token are kept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (scan_res.restart)
            begin
                store_reg[0] <= char_in.char_code;
            end
            else if (scan_res.push && count_reg < 8'(KEPT_CHARS))
            begin
                store_reg[count_reg[IDX_W-1:0]] <= char_in.char_code;
            end
        end
    end

    a_tokens_show_up: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && scan_res.n != 2'd0) |=> token_out.valid)
        else $error("token produced but output not valid");

    a_held_only_when_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg != slts_pkg::CH_NUL) |->
            (mode_reg == slts_pkg::MODE_OP || mode_reg == slts_pkg::MODE_SLASH ||
             mode_reg == slts_pkg::MODE_BLOCK))
        else $error("held character outside operator, slash or block comment");

    a_op_holds_operator: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == slts_pkg::MODE_OP) |->
            (held_reg == slts_pkg::CH_LT || held_reg == slts_pkg::CH_GT ||
             held_reg == slts_pkg::CH_BANG || held_reg == slts_pkg::CH_EQ))
        else $error("operator mode without a pending operator");

    a_queue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.level <= slts_pkg::TQ_LVL_W'(slts_pkg::TQ_DEPTH))
        else $error("token queue overflow");

endmodule

`default_nettype wire
